// ===== rtl/core/eusa_pkg.sv =====
package eusa_pkg;

    // field widths
    localparam int ID_W     = 11;
    localparam int POS_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int TURN_W   = 32;
    localparam int CONT_W   = 32;
    localparam int SPEED_W  = 17;
    localparam int DIFF_W   = SPEED_W + 1;

    // APB
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int NUM_IDS  = 4;
    localparam int NUM_CH   = 2;

    // frame decimation
    localparam int DECIMATE    = 10;
    localparam int COUNT_LIMIT = 10000;
    localparam int DEC_LIMIT   = COUNT_LIMIT / DECIMATE;
    localparam int ONES_W      = $clog2(DECIMATE);
    localparam int DEC_W       = $clog2(DEC_LIMIT + 1);

    // unwrap
    localparam int JUMP_LIMIT = 7500;
    localparam int TURN_SPAN  = 8192;
    localparam int TURN_SHIFT = $clog2(TURN_SPAN);

    // speed history, depth must be a power of two (mean is a shift)
    localparam int HIST_DEPTH = 8;
    localparam int HIST_SHIFT = $clog2(HIST_DEPTH);
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SUM_W      = SPEED_W + HIST_SHIFT + 1;

    // reset values of the identifier registers
    localparam logic [ID_W-1:0] ID_RST [NUM_IDS] = '{11'h201, 11'h202, 11'h203, 11'h204};

    typedef enum logic [2:0] {
        REG_ID_CH0_PRI = 3'd0,
        REG_ID_CH1_PRI = 3'd1,
        REG_ID_CH0_SEC = 3'd2,
        REG_ID_CH1_SEC = 3'd3,
        REG_BIAS_CH0   = 3'd4,
        REG_BIAS_CH1   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [NUM_IDS-1:0][ID_W-1:0]  id;
        logic [NUM_CH-1:0][POS_W-1:0]  bias;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_low;
        logic [BYTE_W-1:0] data_high;
        logic [ID_W-1:0]   frame_id;
    } frame_t;

    typedef struct packed {
        logic                      channel;
        logic signed [SPEED_W-1:0] speed_filtered;
        logic signed [SPEED_W-1:0] speed_raw;
        logic signed [CONT_W-1:0]  continuous_position;
        logic signed [TURN_W-1:0]  turn_count;
        logic [POS_W-1:0]          raw_position;
    } result_t;

endpackage

// ===== rtl/core/eusa_cfg.sv =====
module eusa_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eusa_pkg::APB_AW-1:0]   paddr,
    input  logic [eusa_pkg::APB_DW-1:0]   pwdata,
    output logic [eusa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output eusa_pkg::cfg_t                cfg
);

    eusa_pkg::cfg_t   cfg_reg;
    eusa_pkg::reg_idx_t idx;
    logic             wr;

    assign pready = 1'b1;
    assign idx    = eusa_pkg::reg_idx_t'(paddr[eusa_pkg::APB_AW-1:2]);
    assign wr     = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < eusa_pkg::NUM_IDS; i++) begin
                cfg_reg.id[i] <= eusa_pkg::ID_RST[i];
            end
            cfg_reg.bias <= '0;
        end else if (wr) begin
            unique case (idx)
                eusa_pkg::REG_ID_CH0_PRI: cfg_reg.id[0] <= pwdata[eusa_pkg::ID_W-1:0];
                eusa_pkg::REG_ID_CH1_PRI: cfg_reg.id[1] <= pwdata[eusa_pkg::ID_W-1:0];
                eusa_pkg::REG_ID_CH0_SEC: cfg_reg.id[2] <= pwdata[eusa_pkg::ID_W-1:0];
                eusa_pkg::REG_ID_CH1_SEC: cfg_reg.id[3] <= pwdata[eusa_pkg::ID_W-1:0];
                eusa_pkg::REG_BIAS_CH0:   cfg_reg.bias[0] <= pwdata[eusa_pkg::POS_W-1:0];
                eusa_pkg::REG_BIAS_CH1:   cfg_reg.bias[1] <= pwdata[eusa_pkg::POS_W-1:0];
                default: ;  // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            eusa_pkg::REG_ID_CH0_PRI: prdata[eusa_pkg::ID_W-1:0] = cfg_reg.id[0];
            eusa_pkg::REG_ID_CH1_PRI: prdata[eusa_pkg::ID_W-1:0] = cfg_reg.id[1];
            eusa_pkg::REG_ID_CH0_SEC: prdata[eusa_pkg::ID_W-1:0] = cfg_reg.id[2];
            eusa_pkg::REG_ID_CH1_SEC: prdata[eusa_pkg::ID_W-1:0] = cfg_reg.id[3];
            eusa_pkg::REG_BIAS_CH0:   prdata[eusa_pkg::POS_W-1:0] = cfg_reg.bias[0];
            eusa_pkg::REG_BIAS_CH1:   prdata[eusa_pkg::POS_W-1:0] = cfg_reg.bias[1];
            default: prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/eusa_calc.sv =====
module eusa_calc (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  eusa_pkg::frame_t    frame,
    input  eusa_pkg::cfg_t      cfg,
    output logic                hit,
    output eusa_pkg::result_t   res
);

    // per identifier: ones digit and decade count of the frame counter
    logic [eusa_pkg::ONES_W-1:0] ones_reg [eusa_pkg::NUM_IDS];
    logic [eusa_pkg::DEC_W-1:0]  dec_reg  [eusa_pkg::NUM_IDS];

    // per channel state
    logic [eusa_pkg::POS_W-1:0]         prev_reg  [eusa_pkg::NUM_CH];
    logic signed [eusa_pkg::TURN_W-1:0] turns_reg [eusa_pkg::NUM_CH];
    logic [eusa_pkg::IDX_W-1:0]         idx_reg   [eusa_pkg::NUM_CH];
    logic signed [eusa_pkg::SUM_W-1:0]  sum_reg   [eusa_pkg::NUM_CH];
    logic signed [eusa_pkg::SPEED_W-1:0] hist_reg [eusa_pkg::NUM_CH][eusa_pkg::HIST_DEPTH];

    logic                               match;
    logic [1:0]                         slot;
    logic                               ch;
    logic                               tenth;
    logic [eusa_pkg::POS_W-1:0]         pos;
    logic signed [eusa_pkg::DIFF_W-1:0] diff;
    logic signed [eusa_pkg::DIFF_W-1:0] speed_w;
    logic signed [eusa_pkg::SPEED_W-1:0] speed;
    logic signed [eusa_pkg::TURN_W-1:0] turns_next;
    logic [eusa_pkg::CONT_W-1:0]        cont;
    logic signed [eusa_pkg::SPEED_W-1:0] old_speed;
    logic signed [eusa_pkg::SUM_W-1:0]  sum_next;
    logic signed [eusa_pkg::SUM_W-1:0]  sum_adj;
    logic signed [eusa_pkg::SUM_W-1:0]  mean_w;
    logic [eusa_pkg::IDX_W-1:0]         idx_next;

    // first match wins: primary 0, primary 1, secondary 0, secondary 1
    always_comb begin
        match = 1'b0;
        slot  = 2'd0;
        for (int i = eusa_pkg::NUM_IDS - 1; i >= 0; i--) begin
            if (cfg.id[i] == frame.frame_id) begin
                match = 1'b1;
                slot  = 2'(i);
            end
        end
    end

    assign ch    = slot[0];
    assign tenth = (ones_reg[slot] == eusa_pkg::ONES_W'(eusa_pkg::DECIMATE - 1));
    assign hit   = match & tenth;
    assign pos   = {frame.data_high, frame.data_low};

    always_comb begin
        diff = $signed({2'b00, pos}) - $signed({2'b00, prev_reg[ch]});
        if (diff < -eusa_pkg::DIFF_W'(eusa_pkg::JUMP_LIMIT)) begin
            turns_next = turns_reg[ch] + 32'sd1;
            speed_w    = diff + eusa_pkg::DIFF_W'(eusa_pkg::TURN_SPAN);
        end else if (diff > eusa_pkg::DIFF_W'(eusa_pkg::JUMP_LIMIT)) begin
            turns_next = turns_reg[ch] - 32'sd1;
            speed_w    = diff - eusa_pkg::DIFF_W'(eusa_pkg::TURN_SPAN);
        end else begin
            turns_next = turns_reg[ch];
            speed_w    = diff;
        end
        speed = speed_w[eusa_pkg::SPEED_W-1:0];

        cont = {16'b0, pos} - {16'b0, cfg.bias[ch]}
             + (eusa_pkg::CONT_W'(turns_next) << eusa_pkg::TURN_SHIFT);

        // running sum over the history ring
        old_speed = hist_reg[ch][idx_reg[ch]];
        sum_next  = sum_reg[ch] - eusa_pkg::SUM_W'(old_speed) + eusa_pkg::SUM_W'(speed);
        // divide by depth, rounding toward zero
        sum_adj   = sum_next[eusa_pkg::SUM_W-1]
                  ? sum_next + eusa_pkg::SUM_W'(eusa_pkg::HIST_DEPTH - 1) : sum_next;
        mean_w    = sum_adj >>> eusa_pkg::HIST_SHIFT;

        if (idx_reg[ch] == eusa_pkg::IDX_W'(eusa_pkg::HIST_DEPTH - 1)) begin
            idx_next = '0;
        end else begin
            idx_next = idx_reg[ch] + 1'b1;
        end
    end

    always_comb begin
        res.channel             = ch;
        res.raw_position        = pos;
        res.turn_count          = turns_next;
        res.continuous_position = $signed(cont);
        res.speed_raw           = speed;
        res.speed_filtered      = mean_w[eusa_pkg::SPEED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < eusa_pkg::NUM_IDS; i++) begin
                ones_reg[i] <= '0;
                dec_reg[i]  <= '0;
            end
            for (int c = 0; c < eusa_pkg::NUM_CH; c++) begin
                prev_reg[c]  <= '0;
                turns_reg[c] <= '0;
                idx_reg[c]   <= '0;
                sum_reg[c]   <= '0;
                for (int k = 0; k < eusa_pkg::HIST_DEPTH; k++) begin
                    hist_reg[c][k] <= '0;
                end
            end
        end else if (go && match) begin
            if (tenth) begin
                ones_reg[slot] <= '0;
                if (dec_reg[slot] == eusa_pkg::DEC_W'(eusa_pkg::DEC_LIMIT - 1)) begin
                    dec_reg[slot] <= '0;
                end else begin
                    dec_reg[slot] <= dec_reg[slot] + 1'b1;
                end
                prev_reg[ch]              <= pos;
                turns_reg[ch]             <= turns_next;
                hist_reg[ch][idx_reg[ch]] <= speed;
                sum_reg[ch]               <= sum_next;
                idx_reg[ch]               <= idx_next;
            end else begin
                ones_reg[slot] <= ones_reg[slot] + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/encoder_unwrap_speed_average.sv =====
// A word accepted at the slave side passes through the input register and then the result
// register before it appears at the master side.
// Throughput: one word per cycle while m_tready does not stall the output; the per-channel
// running sum lets each frame finish in a single pass through the update logic.
// Frames that match no identifier, or are not a tenth frame, yield no output word.
// Reset (aresetn low, synchronous): counters, positions, turns and history cleared.
module encoder_unwrap_speed_average (
    input  logic                          aclk,
    input  logic                          aresetn,

    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // frame_id[10:0], data_high[18:11],
                                                     // data_low[26:19], zero pad
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [119:0]                  m_tdata,   // raw_position[15:0], turn_count[47:16],
                                                     // continuous_position[79:48],
                                                     // speed_raw[96:80],
                                                     // speed_filtered[113:97], zero pad
    output logic                          m_tuser,   // channel

    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eusa_pkg::APB_AW-1:0]   paddr,
    input  logic [eusa_pkg::APB_DW-1:0]   pwdata,
    output logic [eusa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    eusa_pkg::cfg_t    cfg;
    eusa_pkg::frame_t  in_reg;
    logic              in_v_reg;
    eusa_pkg::result_t out_reg;
    logic              out_v_reg;
    eusa_pkg::result_t res;
    logic              hit;
    logic              adv;
    logic              go;

    // the output stage can take a new result when empty or being drained
    assign adv      = !out_v_reg | m_tready;
    assign s_tready = !in_v_reg | adv;
    assign go       = in_v_reg & adv;

    eusa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // frame matching, decimation, unwrap and averaging, all in one pass
    eusa_calc u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go),
        .frame   (in_reg),
        .cfg     (cfg),
        .hit     (hit),
        .res     (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_v_reg <= 1'b1;
        end else if (adv) begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata[26:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= go & hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && hit) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.channel;
    assign m_tdata  = {6'b0, out_reg.speed_filtered, out_reg.speed_raw,
                       out_reg.continuous_position, out_reg.turn_count,
                       out_reg.raw_position};

endmodule
